// ===== sv/msme_pkg.sv =====
// Package for the multi-stack move engine.
// Holds field widths, storage sizes, operation and status codes and the sequencer state type.
// No dependencies; every other file of the block imports it.
package msme_pkg;

  // Storage sizes.
  localparam int NUM_STACKS  = 16;
  localparam int STACK_DEPTH = 64;
  localparam int STK_W       = $clog2(NUM_STACKS);
  localparam int POS_W       = $clog2(STACK_DEPTH);
  localparam int HGT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = STK_W + POS_W;
  localparam int MEM_DEPTH   = NUM_STACKS * STACK_DEPTH;

  // Field widths of the request, result and configuration channels.
  localparam int KIND_W   = 2;
  localparam int CRATE_W  = 8;
  localparam int COUNT_W  = 7;
  localparam int IDX_W    = 4;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 2;

  // Width that holds a height plus a move count without wrapping.
  localparam int SUM_W = ((HGT_W > COUNT_W) ? HGT_W : COUNT_W) + 1;

  // Reset value of the stacks-in-use register.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(9);

  // Operation codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HSRC,
    S_HDST,
    S_CHECK,
    S_PEEK,
    S_MOVE,
    S_COMMIT,
    S_DONE
  } state_e;

endpackage

// ===== sv/msme_in_if.sv =====
// Request channel of the multi-stack move engine.
// Carries valid, ready and the request fields; depends on msme_pkg.
interface msme_in_if
  import msme_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CRATE_W-1:0] crate_value;
  logic [COUNT_W-1:0] move_count;
  logic [IDX_W-1:0]   source_stack;
  logic [IDX_W-1:0]   target_stack;

  modport source (output valid, kind, crate_value, move_count, source_stack, target_stack,
                  input ready);
  modport sink   (input valid, kind, crate_value, move_count, source_stack, target_stack,
                  output ready);
endinterface

// ===== sv/msme_out_if.sv =====
// Result channel of the multi-stack move engine.
// Carries valid, ready and the result fields; depends on msme_pkg.
interface msme_out_if
  import msme_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CRATE_W-1:0]  top_crate;
  logic                stack_empty;
  logic [STATUS_W-1:0] status;

  modport source (output valid, top_crate, stack_empty, status, input ready);
  modport sink   (input valid, top_crate, stack_empty, status, output ready);
endinterface

// ===== sv/msme_cfg_if.sv =====
// Configuration write channel of the multi-stack move engine.
// Carries valid, ready and the stacks-in-use value; depends on msme_pkg.
interface msme_cfg_if
  import msme_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] stacks_in_use;

  modport source (output valid, stacks_in_use, input ready);
  modport sink   (input valid, stacks_in_use, output ready);
endinterface

// ===== sv/multi_stack_move_engine.sv =====
// Top level of the multi-stack move engine: crate memory, stack heights and sequencer.
// Depends on msme_pkg and the interfaces msme_in_if, msme_out_if and msme_cfg_if.
//
// Usage: a request on in_i pushes a crate, moves crates between stacks or peeks a
// stack top. Each request yields exactly one result on out_o (top crate, empty flag,
// status). cfg_i writes the number of stacks in use; it is always ready and is meant
// to be written while no request is in flight.
// Timing: the block takes one request at a time. A request reads the source height,
// then the target height, then runs the checks; a peek of a non-empty stack then
// reads the top crate, and a move runs its loop and writes back the source height,
// before the result is loaded. The block is ready for the next request in the cycle
// after the result is loaded. The move loop uses the crate memory's read port and
// write port in the same cycle, so one crate moves per cycle.
// Reset: all stacks are empty and stacks-in-use is 9. No clearing pass is needed,
// since only entries below a stack's height are read.
// Stalls: the result sits in an output register. The next request is accepted while
// it waits; that request then holds in its final step until the result is taken.
module multi_stack_move_engine
  import msme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  msme_in_if.sink     in_i,
  msme_out_if.source  out_o,
  msme_cfg_if.sink    cfg_i
);

  // Sequencer and request registers.
  state_e              state_q, state_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [CRATE_W-1:0]  crate_q, crate_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]    src_q, src_d;
  logic [IDX_W-1:0]    dst_q, dst_d;
  logic [HGT_W-1:0]    src_h_q, src_h_d;
  logic [HGT_W-1:0]    dst_h_q, dst_h_d;
  logic [COUNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic [COUNT_W-1:0]  wr_cnt_q, wr_cnt_d;
  logic                wr_pend_q, wr_pend_d;

  // Result under construction and output register.
  logic [CRATE_W-1:0]  res_top_q, res_top_d;
  logic                res_empty_q, res_empty_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [CRATE_W-1:0]  out_top_q, out_top_d;
  logic                out_empty_q, out_empty_d;
  status_e             out_status_q, out_status_d;
  logic                res_load;

  // Configuration register.
  logic [CFG_W-1:0]    cfg_q;

  // Stack heights, one read port and one write port.
  logic [HGT_W-1:0]    heights_q [NUM_STACKS];
  logic [STK_W-1:0]    h_raddr;
  logic [HGT_W-1:0]    h_rdata;
  logic                h_we;
  logic [STK_W-1:0]    h_waddr;
  logic [HGT_W-1:0]    h_wdata;

  // Crate memory, one write port and one registered read port.
  logic [CRATE_W-1:0]  mem [MEM_DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CRATE_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CRATE_W-1:0]  mem_rdata_q;

  logic                src_ok;
  logic                dst_ok;
  logic [HGT_W-1:0]    src_h_m1;
  logic                in_ready;

  // A stack index is usable when below both the configured count and the bank size.
  function automatic logic index_ok(logic [IDX_W-1:0] s, logic [CFG_W-1:0] lim);
    logic below_cfg;
    logic below_bank;
    below_cfg  = (SUM_W'(s) < SUM_W'(lim));
    below_bank = (SUM_W'(s) < SUM_W'(NUM_STACKS));
    return below_cfg && below_bank;
  endfunction

  assign src_ok   = index_ok(src_q, cfg_q);
  assign dst_ok   = index_ok(dst_q, cfg_q);
  assign src_h_m1 = src_h_q - HGT_W'(1);
  assign h_rdata  = heights_q[h_raddr];

  // Channel outputs.
  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.top_crate   = out_top_q;
  assign out_o.stack_empty = out_empty_q;
  assign out_o.status      = out_status_q;
  assign cfg_i.ready       = 1'b1;

  // Next state, datapath updates and memory controls.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    crate_d      = crate_q;
    count_d      = count_q;
    src_d        = src_q;
    dst_d        = dst_q;
    src_h_d      = src_h_q;
    dst_h_d      = dst_h_q;
    rd_cnt_d     = rd_cnt_q;
    wr_cnt_d     = wr_cnt_q;
    wr_pend_d    = wr_pend_q;
    res_top_d    = res_top_q;
    res_empty_d  = res_empty_q;
    res_status_d = res_status_q;
    in_ready     = 1'b0;
    res_load     = 1'b0;
    h_raddr      = src_q[STK_W-1:0];
    h_we         = 1'b0;
    h_waddr      = dst_q[STK_W-1:0];
    h_wdata      = dst_h_q + HGT_W'(1);
    mem_we       = 1'b0;
    mem_waddr    = {dst_q[STK_W-1:0], dst_h_q[POS_W-1:0]};
    mem_wdata    = crate_q;
    mem_re       = 1'b0;
    mem_raddr    = {src_q[STK_W-1:0], src_h_m1[POS_W-1:0]};

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          kind_d  = in_i.kind;
          crate_d = in_i.crate_value;
          count_d = in_i.move_count;
          src_d   = in_i.source_stack;
          dst_d   = in_i.target_stack;
          state_d = S_HSRC;
        end
      end

      S_HSRC: begin
        h_raddr = src_q[STK_W-1:0];
        src_h_d = h_rdata;
        state_d = S_HDST;
      end

      S_HDST: begin
        h_raddr = dst_q[STK_W-1:0];
        dst_h_d = h_rdata;
        state_d = S_CHECK;
      end

      // Checks in order: bad index, underflow, overflow; then start the work.
      S_CHECK: begin
        res_top_d    = '0;
        res_empty_d  = 1'b0;
        res_status_d = ST_OK;
        state_d      = S_DONE;
        unique case (kind_q)
          KIND_PUSH: begin
            if (!dst_ok) begin
              res_status_d = ST_BAD_INDEX;
            end else if (dst_h_q >= HGT_W'(STACK_DEPTH)) begin
              res_status_d = ST_OVERFLOW;
            end else begin
              mem_we = 1'b1;
              h_we   = 1'b1;
            end
          end
          KIND_MOVE: begin
            if (!src_ok || !dst_ok) begin
              res_status_d = ST_BAD_INDEX;
            end else if (SUM_W'(count_q) > SUM_W'(src_h_q)) begin
              res_status_d = ST_UNDERFLOW;
            end else if ((src_q != dst_q) &&
                         (SUM_W'(dst_h_q) + SUM_W'(count_q) > SUM_W'(STACK_DEPTH))) begin
              res_status_d = ST_OVERFLOW;
            end else if ((src_q != dst_q) && (count_q != '0)) begin
              rd_cnt_d  = count_q;
              wr_cnt_d  = count_q;
              wr_pend_d = 1'b0;
              state_d   = S_MOVE;
            end
          end
          KIND_PEEK: begin
            if (!src_ok) begin
              res_status_d = ST_BAD_INDEX;
            end else if (src_h_q == '0) begin
              res_empty_d = 1'b1;
            end else begin
              mem_re  = 1'b1;
              state_d = S_PEEK;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_PEEK: begin
        res_top_d = mem_rdata_q;
        state_d   = S_DONE;
      end

      // Read one crate off the source and write the previous one onto the target.
      S_MOVE: begin
        wr_pend_d = (rd_cnt_q != '0);
        if (rd_cnt_q != '0) begin
          mem_re   = 1'b1;
          src_h_d  = src_h_m1;
          rd_cnt_d = rd_cnt_q - COUNT_W'(1);
        end
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_q;
          dst_h_d   = dst_h_q + HGT_W'(1);
          wr_cnt_d  = wr_cnt_q - COUNT_W'(1);
          if (wr_cnt_q == COUNT_W'(1)) begin
            h_we    = 1'b1;
            state_d = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        h_we    = 1'b1;
        h_waddr = src_q[STK_W-1:0];
        h_wdata = src_h_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: cleared when taken, loaded when a result is finished.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_top_d    = out_top_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_load) begin
      out_valid_d  = 1'b1;
      out_top_d    = res_top_q;
      out_empty_d  = res_empty_q;
      out_status_d = res_status_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= CFG_RESET;
    end else begin
      state_q     <= state_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.stacks_in_use;
      end
    end
  end

  // Stack heights start at zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        heights_q[i] <= '0;
      end
    end else if (h_we) begin
      heights_q[h_waddr] <= h_wdata;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    crate_q      <= crate_d;
    count_q      <= count_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    src_h_q      <= src_h_d;
    dst_h_q      <= dst_h_d;
    rd_cnt_q     <= rd_cnt_d;
    wr_cnt_q     <= wr_cnt_d;
    res_top_q    <= res_top_d;
    res_empty_q  <= res_empty_d;
    res_status_q <= res_status_d;
    out_top_q    <= out_top_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  // Crate memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // A stored height never exceeds the stack depth.
  a_height_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_we |-> (SUM_W'(h_wdata) <= SUM_W'(STACK_DEPTH)))
    else $error("stack height written beyond depth");

  // The move loop only runs between two distinct stacks.
  a_move_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (src_q != dst_q))
    else $error("move loop with source equal to target");

  // Writes never run ahead of reads in the move loop.
  a_move_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (wr_cnt_q >= rd_cnt_q))
    else $error("move loop wrote more crates than it read");

  // A rejected index gives neither a crate nor an empty flag.
  a_bad_index_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && (res_status_q == ST_BAD_INDEX)) |-> ((res_top_q == '0) && !res_empty_q))
    else $error("bad index result carries data");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> (state_q == S_HSRC))
    else $error("accepted request did not start");

endmodule

// ===== tb/multi_stack_move_engine_tb.sv =====
// Self-checking testbench for the multi-stack move engine. Depends on msme_pkg and the
// msme_in_if/out_if/cfg_if interfaces. Drives push, move, peek and unused-kind requests
// and config writes, and checks each result against the directed table or the internal predictor.
module multi_stack_move_engine_tb
  import msme_pkg::*;
();

  // The one kind code the block does not act on.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [CRATE_W-1:0] crate;
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   src;
    logic [IDX_W-1:0]   dst;
  } request_t;

  typedef struct {
    logic [CRATE_W-1:0] top;
    logic               empty;
    status_e            status;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } plan_row_t;

  logic clk;
  logic rst_n;

  msme_in_if  req_ch ();
  msme_out_if res_ch ();
  msme_cfg_if cfg_ch ();

  multi_stack_move_engine dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // Predictor copy of the stacks and the stacks-in-use register.
  int unsigned        stack_fill [NUM_STACKS];
  logic [CRATE_W-1:0] crate_mem  [NUM_STACKS][STACK_DEPTH];
  logic [CFG_W-1:0]   stacks_live;

  result_t     awaited_results [$];
  plan_row_t   directed_plan [$];
  result_t     no_result;
  int unsigned mismatch_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one request to the predictor state and returns the result it should produce.
  function automatic result_t predict_stack_op(request_t r);
    result_t     res;
    int unsigned usable;
    int unsigned k;
    res.top    = '0;
    res.empty  = 1'b0;
    res.status = ST_OK;
    usable = (stacks_live > NUM_STACKS) ? NUM_STACKS : stacks_live;
    case (r.kind)
      KIND_PUSH: begin
        if (r.dst >= usable) begin
          res.status = ST_BAD_INDEX;
        end else if (stack_fill[r.dst] >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          crate_mem[r.dst][stack_fill[r.dst]] = r.crate;
          stack_fill[r.dst]++;
        end
      end
      KIND_MOVE: begin
        if (r.src >= usable || r.dst >= usable) begin
          res.status = ST_BAD_INDEX;
        end else if (r.count > stack_fill[r.src]) begin
          res.status = ST_UNDERFLOW;
        end else if (r.src != r.dst && stack_fill[r.dst] + r.count > STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else if (r.src != r.dst) begin
          // Crates go over one at a time, so their order flips.
          for (k = 0; k < r.count; k++) begin
            stack_fill[r.src]--;
            crate_mem[r.dst][stack_fill[r.dst]] = crate_mem[r.src][stack_fill[r.src]];
            stack_fill[r.dst]++;
          end
        end
      end
      KIND_PEEK: begin
        if (r.src >= usable) begin
          res.status = ST_BAD_INDEX;
        end else if (stack_fill[r.src] == 0) begin
          res.empty = 1'b1;
        end else begin
          res.top = crate_mem[r.src][stack_fill[r.src] - 1];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly a stack in use; now and then any index, which may be out of range.
  function automatic logic [IDX_W-1:0] pick_stack(int unsigned usable);
    if (usable == 0 || $urandom_range(9) == 0) begin
      return IDX_W'($urandom_range(NUM_STACKS - 1));
    end
    return IDX_W'($urandom_range(usable - 1));
  endfunction

  // Builds a mostly well-formed request from the current stack heights.
  function automatic request_t random_request();
    request_t    r;
    int unsigned usable;
    int unsigned roll;
    int unsigned room;
    usable  = (stacks_live > NUM_STACKS) ? NUM_STACKS : stacks_live;
    r.crate = CRATE_W'($urandom_range(255));
    r.count = '0;
    r.src   = pick_stack(usable);
    r.dst   = pick_stack(usable);
    roll    = $urandom_range(99);
    if (roll < 46) begin
      r.kind = KIND_PUSH;
    end else if (roll < 76) begin
      r.kind = KIND_MOVE;
      room   = stack_fill[r.src];
      roll   = $urandom_range(99);
      // Short moves that fit dominate; long and oversized ones probe the limits.
      if (roll < 70) begin
        r.count = COUNT_W'($urandom_range((room < 8) ? room : 8));
      end else if (roll < 85) begin
        r.count = COUNT_W'($urandom_range(room));
      end else if (roll < 95) begin
        r.count = COUNT_W'($urandom_range(STACK_DEPTH));
      end else begin
        r.count = COUNT_W'(STACK_DEPTH);
      end
    end else begin
      r.kind = KIND_PEEK;
    end
    return r;
  endfunction

  task automatic add_row(logic [KIND_W-1:0] kind, logic [CRATE_W-1:0] crate,
                         logic [COUNT_W-1:0] count, logic [IDX_W-1:0] src,
                         logic [IDX_W-1:0] dst, bit typed, logic [CRATE_W-1:0] top,
                         logic empty, status_e status);
    plan_row_t row;
    row.req.kind   = kind;
    row.req.crate  = crate;
    row.req.count  = count;
    row.req.src    = src;
    row.req.dst    = dst;
    row.typed      = typed;
    row.res.top    = top;
    row.res.empty  = empty;
    row.res.status = status;
    directed_plan = {directed_plan, row};
  endtask

  // Offers one request, waits for it to be taken and records the result it owes.
  task automatic send_request(request_t r, bit typed, result_t typed_res);
    result_t predicted;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= r.kind;
    req_ch.crate_value  <= r.crate;
    req_ch.move_count   <= r.count;
    req_ch.source_stack <= r.src;
    req_ch.target_stack <= r.dst;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_stack_op(r);
    if (typed) begin
      awaited_results = {awaited_results, typed_res};
    end else begin
      awaited_results = {awaited_results, predicted};
    end
  endtask

  // Stops offering requests until every owed result has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_stacks_in_use(logic [CFG_W-1:0] value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.stacks_in_use <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    stacks_live = value;
  endtask

  // One random phase: new stack count, new idling mix, then a run of requests.
  task automatic run_phase(logic [CFG_W-1:0] live, int unsigned gap, int unsigned stall,
                           int unsigned n_items, bit pause_midway);
    request_t    r;
    int unsigned done;
    wait_drained();
    write_stacks_in_use(live);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 3) begin
        r.kind  = KIND_UNUSED;
        r.crate = CRATE_W'($urandom_range(255));
        r.count = COUNT_W'($urandom_range(STACK_DEPTH));
        r.src   = IDX_W'($urandom_range(NUM_STACKS - 1));
        r.dst   = IDX_W'($urandom_range(NUM_STACKS - 1));
        send_request(r, 1'b0, no_result);
      end else begin
        send_request(random_request(), 1'b0, no_result);
        done++;
        if (pause_midway && done == n_items / 2) begin
          wait_drained();
        end
      end
    end
  endtask

  task automatic log_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // Result sink: random backpressure per the current idling mix.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each taken result with the oldest owed one.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (awaited_results.size() == 0) begin
        log_failure($sformatf("unexpected result: top=%h empty=%b status=%0d",
                              res_ch.top_crate, res_ch.stack_empty, res_ch.status));
      end else begin
        want = awaited_results.pop_front();
        if (res_ch.top_crate !== want.top || res_ch.stack_empty !== want.empty ||
            res_ch.status !== want.status) begin
          log_failure($sformatf(
            "result mismatch: expected top=%h empty=%b status=%0d, got top=%h empty=%b status=%0d",
            want.top, want.empty, want.status,
            res_ch.top_crate, res_ch.stack_empty, res_ch.status));
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin : main_sequence
    int i;
    int s;
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= KIND_PUSH;
    req_ch.crate_value  <= '0;
    req_ch.move_count   <= '0;
    req_ch.source_stack <= '0;
    req_ch.target_stack <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.stacks_in_use <= CFG_RESET;
    for (s = 0; s < NUM_STACKS; s++) begin
      stack_fill[s] = 0;
    end
    stacks_live      = CFG_RESET;
    no_result.top    = '0;
    no_result.empty  = 1'b0;
    no_result.status = ST_OK;
    mismatch_count   = 0;
    send_gap_pct     = 0;
    recv_stall_pct   = 0;

    // Directed table, run with the reset stack count of nine.
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd0,  4'd0,  1'b1, 8'h00, 1'b1, ST_OK);
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd9,  4'd0,  1'b1, 8'h00, 1'b0, ST_BAD_INDEX);
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd15, 4'd0,  1'b1, 8'h00, 1'b0, ST_BAD_INDEX);
    add_row(KIND_PUSH,   8'hFF, 7'd0,  4'd0,  4'd0,  1'b1, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PUSH,   8'h00, 7'd0,  4'd0,  4'd0,  1'b1, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PUSH,   8'hA5, 7'd0,  4'd0,  4'd8,  1'b1, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PUSH,   8'h5A, 7'd0,  4'd0,  4'd9,  1'b1, 8'h00, 1'b0, ST_BAD_INDEX);
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd0,  4'd0,  1'b0, 8'h00, 1'b0, ST_OK);
    add_row(KIND_MOVE,   8'h00, 7'd1,  4'd0,  4'd8,  1'b0, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd8,  4'd0,  1'b0, 8'h00, 1'b0, ST_OK);
    add_row(KIND_MOVE,   8'h00, 7'd3,  4'd0,  4'd1,  1'b1, 8'h00, 1'b0, ST_UNDERFLOW);
    add_row(KIND_MOVE,   8'h00, 7'd0,  4'd2,  4'd3,  1'b1, 8'h00, 1'b0, ST_OK);
    add_row(KIND_MOVE,   8'h00, 7'd2,  4'd8,  4'd8,  1'b1, 8'h00, 1'b0, ST_OK);
    add_row(KIND_MOVE,   8'h00, 7'd5,  4'd8,  4'd8,  1'b1, 8'h00, 1'b0, ST_UNDERFLOW);
    add_row(KIND_MOVE,   8'h00, 7'd1,  4'd9,  4'd0,  1'b1, 8'h00, 1'b0, ST_BAD_INDEX);
    add_row(KIND_MOVE,   8'h00, 7'd1,  4'd0,  4'd15, 1'b1, 8'h00, 1'b0, ST_BAD_INDEX);
    add_row(KIND_MOVE,   8'h00, 7'd64, 4'd8,  4'd0,  1'b1, 8'h00, 1'b0, ST_UNDERFLOW);
    add_row(KIND_UNUSED, 8'hFF, 7'd64, 4'd15, 4'd15, 1'b1, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd8,  4'd0,  1'b0, 8'h00, 1'b0, ST_OK);
    add_row(KIND_MOVE,   8'h00, 7'd2,  4'd8,  4'd0,  1'b0, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd0,  4'd0,  1'b0, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PUSH,   8'h80, 7'd0,  4'd0,  4'd8,  1'b0, 8'h00, 1'b0, ST_OK);
    add_row(KIND_PEEK,   8'h00, 7'd0,  4'd8,  4'd0,  1'b0, 8'h00, 1'b0, ST_OK);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < directed_plan.size(); i++) begin
      send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].res);
    end

    // Random phases: stack count, sender gap percent, receiver stall percent, count, midway drain.
    run_phase(CFG_W'(16), 0,  0,  200, 1'b0);
    run_phase(CFG_W'(1),  63, 0,  200, 1'b0);
    run_phase(CFG_W'(2),  0,  63, 250, 1'b0);
    run_phase(CFG_W'(16), 31, 31, 250, 1'b1);
    run_phase(CFG_W'(5),  0,  0,  150, 1'b0);
    run_phase(CFG_RESET,  31, 31, 200, 1'b0);

    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== multi_stack_move_engine.f =====
sv/msme_pkg.sv
sv/msme_in_if.sv
sv/msme_out_if.sv
sv/msme_cfg_if.sv
sv/multi_stack_move_engine.sv
tb/multi_stack_move_engine_tb.sv
